@@ sv/slcd_pkg.sv @@
// Shared types and constants for the sync/length/checksum deframer.
package slcd_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int SUM_W       = 32;
   localparam int PARTIAL_W   = 24;
   localparam int STEP_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_FIELD_W = 83;
   localparam int RSP_DATA_W  = 88;

   typedef enum logic [3:0] {
      PH_SYNC = 4'd0,
      PH_SUB1 = 4'd1,
      PH_SUB2 = 4'd2,
      PH_PID  = 4'd3,
      PH_TID  = 4'd4,
      PH_CODE = 4'd5,
      PH_LEN  = 4'd6,
      PH_DATA = 4'd7,
      PH_CHK  = 4'd8
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_VALUE      = 3'd0,
      CSR_SUB_SYNC_VALUE  = 3'd1,
      CSR_SUB_SYNC2_VALUE = 3'd2,
      CSR_SUB_SYNC_ENABLE = 3'd3,
      CSR_TYPE_MASK       = 3'd4,
      CSR_EXPECTED_TYPE   = 3'd5,
      CSR_RESPONSE_TYPE   = 3'd6,
      CSR_DATA_TYPE       = 3'd7
   } csr_index_type;

   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TYPE_MISMATCH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH_RSP  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISMATCH_DATA = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CHECKSUM_FAIL = 3'd4;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   localparam logic [STEP_W-1:0] CHK_LAST_STEP = 2'd3;

endpackage

@@ sv/sync_length_checksum_deframer.sv @@
// Byte-stream packet deframer: sync, sub-sync, header, payload, 32-bit check word.
// An accepted byte sits in the input register, is parsed into the result register, and its
// result (if any) is on rsp_ from then on.
// Throughput: one byte per cycle while the rsp_ side does not stall; the parse step is one
// phase update and one 32-bit add. A stalled rsp_ side holds the result register; the input
// register still takes a byte when the result register is being emptied in the same cycle.
// Reset (synchronous, active high) clears all parser state and all configuration registers.
module sync_length_checksum_deframer (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: [7:0] rx_byte
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [slcd_pkg::REQ_DATA_W-1:0]        req_tdata,
   // rsp_tdata: [7:0] payload_byte, [23:8] payload_index, [31:24] packet_id,
   //   [47:32] transaction_id, [63:48] command_code, [79:64] payload_length,
   //   [82:80] status, [87:83] zero
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [slcd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // rsp_tuser: [0] result_kind
   output logic                                   rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [slcd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [slcd_pkg::BYTE_W-1:0]            csr_data
);
   import slcd_pkg::*;

   // configuration
   logic [BYTE_W-1:0] sync_value_ff, sub_sync_value_ff, sub_sync2_value_ff;
   logic              sub_sync_enable_ff;
   logic [BYTE_W-1:0] type_mask_ff, expected_type_ff, response_type_ff, data_type_ff;

   // input stage
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // parser state
   phase_type            phase_ff, phase_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [PARTIAL_W-1:0] partial_ff, partial_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [WORD_W-1:0]    left_ff, left_in;
   logic [WORD_W-1:0]    idx_ff, idx_in;
   logic [BYTE_W-1:0]    prev_ff;
   logic [BYTE_W-1:0]    hid_ff, hid_in;
   logic [WORD_W-1:0]    htid_ff, htid_in;
   logic [WORD_W-1:0]    hcode_ff, hcode_in;
   logic [WORD_W-1:0]    hlen_ff, hlen_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_kind_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // parse-step signals
   logic                 proc_fire;
   logic                 resync;
   phase_type            ph;
   logic [SUM_W-1:0]     sum_base;
   logic [STEP_W-1:0]    step_base;
   logic [WORD_W-1:0]    idx_base;
   logic [WORD_W-1:0]    word;
   logic [WORD_W-1:0]    left_dec;
   logic [SUM_W-1:0]     chk_sum;
   logic [BYTE_W-1:0]    pkt_type;
   logic                 res_valid;
   logic                 res_kind;
   logic [STATUS_W-1:0]  res_status;
   logic [RSP_FIELD_W-1:0] res_fields;
   logic [BYTE_W-1:0]    b;

   assign b         = in_byte_ff;
   assign proc_fire = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || proc_fire;
   assign csr_ready = 1'b1;

   // sync followed by sub-sync restarts the packet from any phase but the first sub-sync
   assign resync = sub_sync_enable_ff && (b == sub_sync_value_ff) &&
                   (prev_ff == sync_value_ff) && (phase_ff != PH_SUB1);
   assign ph        = resync ? PH_SUB1 : phase_ff;
   assign sum_base  = resync ? {{(SUM_W-BYTE_W){1'b0}}, sync_value_ff} : sum_ff;
   assign step_base = resync ? '0 : step_ff;
   assign idx_base  = resync ? '0 : idx_ff;

   assign word     = {b, partial_ff[BYTE_W-1:0]};
   assign left_dec = left_ff - 1'b1;
   assign chk_sum  = sum_base + {b, partial_ff};
   assign pkt_type = hid_ff & type_mask_ff;

   // next parser state
   always_comb begin
      phase_in   = ph;
      step_in    = step_base;
      partial_in = partial_ff;
      sum_in     = sum_base;
      left_in    = left_ff;
      idx_in     = idx_base;
      hid_in     = hid_ff;
      htid_in    = htid_ff;
      hcode_in   = hcode_ff;
      hlen_in    = hlen_ff;
      case (ph)
         PH_SYNC: begin
            if (b == sync_value_ff) begin
               sum_in   = {{(SUM_W-BYTE_W){1'b0}}, b};
               phase_in = sub_sync_enable_ff ? PH_SUB1 : PH_PID;
            end
         end
         PH_SUB1: begin
            if (b == sub_sync_value_ff) begin
               sum_in   = sum_base + {{(SUM_W-BYTE_W){1'b0}}, b};
               phase_in = PH_SUB2;
            end else begin
               phase_in = PH_SYNC;
            end
         end
         PH_SUB2: begin
            if (b == sub_sync2_value_ff) begin
               sum_in   = sum_base + {{(SUM_W-BYTE_W){1'b0}}, b};
               phase_in = PH_PID;
            end else begin
               phase_in = PH_SYNC;
            end
         end
         PH_PID: begin
            hid_in   = b;
            sum_in   = sum_base + {{(SUM_W-BYTE_W){1'b0}}, b};
            step_in  = '0;
            phase_in = PH_TID;
         end
         PH_TID, PH_CODE, PH_LEN: begin
            if (step_base == '0) begin
               partial_in = {{(PARTIAL_W-BYTE_W){1'b0}}, b};
               step_in    = 2'd1;
            end else begin
               sum_in  = sum_base + {{(SUM_W-WORD_W){1'b0}}, word};
               step_in = '0;
               if (ph == PH_TID) begin
                  htid_in  = word;
                  phase_in = PH_CODE;
               end else if (ph == PH_CODE) begin
                  hcode_in = word;
                  phase_in = PH_LEN;
               end else begin
                  hlen_in  = word;
                  left_in  = word;
                  idx_in   = '0;
                  phase_in = (word == '0) ? PH_CHK : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            idx_in  = idx_base + 1'b1;
            sum_in  = sum_base + {{(SUM_W-BYTE_W){1'b0}}, b};
            left_in = left_dec;
            if (left_dec == '0) begin
               step_in  = '0;
               phase_in = PH_CHK;
            end
         end
         PH_CHK: begin
            if (step_base != CHK_LAST_STEP) begin
               case (step_base)
                  2'd0:    partial_in[7:0]   = b;
                  2'd1:    partial_in[15:8]  = b;
                  default: partial_in[23:16] = b;
               endcase
               step_in = step_base + 1'b1;
            end else begin
               sum_in   = chk_sum;
               phase_in = PH_SYNC;
               step_in  = '0;
               idx_in   = '0;
            end
         end
         default: begin
            phase_in = PH_SYNC;
         end
      endcase
   end

   // result of this byte
   always_comb begin
      res_valid  = 1'b0;
      res_kind   = KIND_PAYLOAD;
      res_status = ST_OK;
      res_fields = '0;
      if (chk_sum != '0)                      res_status = ST_CHECKSUM_FAIL;
      else if (pkt_type == expected_type_ff)  res_status = ST_OK;
      else if (pkt_type == response_type_ff)  res_status = ST_MISMATCH_RSP;
      else if (pkt_type == data_type_ff)      res_status = ST_MISMATCH_DATA;
      else                                    res_status = ST_TYPE_MISMATCH;
      case (ph)
         PH_DATA: begin
            res_valid  = 1'b1;
            res_kind   = KIND_PAYLOAD;
            res_fields = {{(RSP_FIELD_W-WORD_W-BYTE_W){1'b0}}, idx_base, b};
         end
         PH_CHK: begin
            if (step_base == CHK_LAST_STEP) begin
               res_valid  = 1'b1;
               res_kind   = KIND_END;
               res_fields = {res_status, hlen_ff, hcode_ff, htid_ff, hid_ff,
                             {(WORD_W+BYTE_W){1'b0}}};
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff      <= '0;
         sub_sync_value_ff  <= '0;
         sub_sync2_value_ff <= '0;
         sub_sync_enable_ff <= 1'b0;
         type_mask_ff       <= '0;
         expected_type_ff   <= '0;
         response_type_ff   <= '0;
         data_type_ff       <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_VALUE:      sync_value_ff      <= csr_data;
            CSR_SUB_SYNC_VALUE:  sub_sync_value_ff  <= csr_data;
            CSR_SUB_SYNC2_VALUE: sub_sync2_value_ff <= csr_data;
            CSR_SUB_SYNC_ENABLE: sub_sync_enable_ff <= csr_data[0];
            CSR_TYPE_MASK:       type_mask_ff       <= csr_data;
            CSR_EXPECTED_TYPE:   expected_type_ff   <= csr_data;
            CSR_RESPONSE_TYPE:   response_type_ff   <= csr_data;
            CSR_DATA_TYPE:       data_type_ff       <= csr_data;
            default:             sync_value_ff      <= sync_value_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[BYTE_W-1:0];
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC;
         step_ff    <= '0;
         partial_ff <= '0;
         sum_ff     <= '0;
         left_ff    <= '0;
         idx_ff     <= '0;
         prev_ff    <= '0;
         hid_ff     <= '0;
         htid_ff    <= '0;
         hcode_ff   <= '0;
         hlen_ff    <= '0;
      end else if (proc_fire) begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         partial_ff <= partial_in;
         sum_ff     <= sum_in;
         left_ff    <= left_in;
         idx_ff     <= idx_in;
         prev_ff    <= b;
         hid_ff     <= hid_in;
         htid_ff    <= htid_in;
         hcode_ff   <= hcode_in;
         hlen_ff    <= hlen_in;
      end
   end

   // result register: load on a parsed beat with a result, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_fire) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_data_ff <= {{(RSP_DATA_W-RSP_FIELD_W){1'b0}}, res_fields};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

@@ dv/deframe_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the deframer: predicts rsp_ beats from accepted bytes and compares them.
module deframe_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [slcd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [slcd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [slcd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [slcd_pkg::BYTE_W-1:0]        csr_data,
   output int                                 fail_count,
   output int                                 outstanding,
   output logic                               at_sync
);
   import slcd_pkg::*;

   typedef struct packed {
      logic                kind;
      logic [7:0]          pay_byte;
      logic [15:0]         pay_index;
      logic [7:0]          pid;
      logic [15:0]         tid;
      logic [15:0]         code;
      logic [15:0]         len;
      logic [STATUS_W-1:0] status;
   } deframe_result_type;

   deframe_result_type pending_results[$];
   int              errors = 0;
   int              result_count = 0;

   // configuration copy
   logic [7:0]  cfg_sync, cfg_sub, cfg_sub2, cfg_mask, cfg_exp, cfg_rsp, cfg_dat;
   logic        cfg_sub_en;

   // parser copy
   phase_type   phase;
   logic [1:0]  step;
   logic [23:0] partial;
   logic [31:0] run_sum;
   logic [15:0] left, idx;
   logic [7:0]  prev_byte, held_id;
   logic [15:0] held_tid, held_code, held_len;

   task automatic report(input string msg);
      if (errors < 50) $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report($sformatf("result %0d field %s got %h want %h", result_count, name, got, want));
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [15:0]     word;
      logic [7:0]      ptype;
      deframe_result_type r;
      r = '0;
      // sync followed by sub-sync restarts the packet from any phase but the first sub-sync
      if (cfg_sub_en && b == cfg_sub && prev_byte == cfg_sync && phase != PH_SUB1) begin
         run_sum = {24'd0, cfg_sync};
         phase   = PH_SUB1;
         step    = '0;
         idx     = '0;
      end
      prev_byte = b;
      case (phase)
         PH_SYNC: begin
            if (b == cfg_sync) begin
               run_sum = {24'd0, b};
               phase   = cfg_sub_en ? PH_SUB1 : PH_PID;
            end
         end
         PH_SUB1: begin
            if (b == cfg_sub) begin
               run_sum += b;
               phase = PH_SUB2;
            end else begin
               phase = PH_SYNC;
            end
         end
         PH_SUB2: begin
            if (b == cfg_sub2) begin
               run_sum += b;
               phase = PH_PID;
            end else begin
               phase = PH_SYNC;
            end
         end
         PH_PID: begin
            held_id = b;
            run_sum += b;
            step  = '0;
            phase = PH_TID;
         end
         PH_TID, PH_CODE, PH_LEN: begin
            if (step == 2'd0) begin
               partial = {16'd0, b};
               step    = 2'd1;
            end else begin
               word = {b, partial[7:0]};
               run_sum += word;
               step = 2'd0;
               if (phase == PH_TID) begin
                  held_tid = word;
                  phase    = PH_CODE;
               end else if (phase == PH_CODE) begin
                  held_code = word;
                  phase     = PH_LEN;
               end else begin
                  held_len = word;
                  left     = word;
                  idx      = '0;
                  phase    = (word == 16'd0) ? PH_CHK : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            r.kind      = KIND_PAYLOAD;
            r.pay_byte  = b;
            r.pay_index = idx;
            idx++;
            run_sum += b;
            left--;
            if (left == 16'd0) begin
               step  = '0;
               phase = PH_CHK;
            end
            pending_results.push_back(r);
         end
         PH_CHK: begin
            if (step != CHK_LAST_STEP) begin
               partial[{step, 3'b000} +: 8] = b;
               step++;
            end else begin
               run_sum += {b, partial};
               ptype = held_id & cfg_mask;
               if (run_sum != 32'd0)     r.status = ST_CHECKSUM_FAIL;
               else if (ptype == cfg_exp) r.status = ST_OK;
               else if (ptype == cfg_rsp) r.status = ST_MISMATCH_RSP;
               else if (ptype == cfg_dat) r.status = ST_MISMATCH_DATA;
               else                       r.status = ST_TYPE_MISMATCH;
               r.kind = KIND_END;
               r.pid  = held_id;
               r.tid  = held_tid;
               r.code = held_code;
               r.len  = held_len;
               pending_results.push_back(r);
               phase = PH_SYNC;
               step  = '0;
               idx   = '0;
            end
         end
         default: phase = PH_SYNC;
      endcase
   endtask

   always @(posedge clock) begin
      deframe_result_type want;
      if (reset) begin
         pending_results.delete();
         {cfg_sync, cfg_sub, cfg_sub2, cfg_mask, cfg_exp, cfg_rsp, cfg_dat} = '0;
         cfg_sub_en = 1'b0;
         phase      = PH_SYNC;
         step       = '0;
         partial    = '0;
         run_sum    = '0;
         left       = '0;
         idx        = '0;
         prev_byte  = '0;
         held_id    = '0;
         held_tid   = '0;
         held_code  = '0;
         held_len   = '0;
      end else begin
         // results first: a byte accepted at this edge cannot have its result yet
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report($sformatf("result %0d with nothing predicted: tuser %b tdata %h",
                                result_count, rsp_tuser, rsp_tdata));
            end else begin
               want = pending_results.pop_front();
               compare_field("result_kind", rsp_tuser, want.kind);
               compare_field("payload_byte", rsp_tdata[7:0], want.pay_byte);
               compare_field("payload_index", rsp_tdata[23:8], want.pay_index);
               compare_field("packet_id", rsp_tdata[31:24], want.pid);
               compare_field("transaction_id", rsp_tdata[47:32], want.tid);
               compare_field("command_code", rsp_tdata[63:48], want.code);
               compare_field("payload_length", rsp_tdata[79:64], want.len);
               compare_field("status", rsp_tdata[82:80], want.status);
               compare_field("pad", rsp_tdata[87:83], 32'd0);
            end
            result_count++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SYNC_VALUE:      cfg_sync   = csr_data;
               CSR_SUB_SYNC_VALUE:  cfg_sub    = csr_data;
               CSR_SUB_SYNC2_VALUE: cfg_sub2   = csr_data;
               CSR_SUB_SYNC_ENABLE: cfg_sub_en = csr_data[0];
               CSR_TYPE_MASK:       cfg_mask   = csr_data;
               CSR_EXPECTED_TYPE:   cfg_exp    = csr_data;
               CSR_RESPONSE_TYPE:   cfg_rsp    = csr_data;
               CSR_DATA_TYPE:       cfg_dat    = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) deframe_byte(req_tdata);
      end
      fail_count  <= errors;
      outstanding <= pending_results.size();
      at_sync     <= (phase == PH_SYNC);
   end

endmodule

@@ dv/tb_sync_length_checksum_deframer.sv @@
`timescale 1ns / 100ps
// Testbench top for the deframer: clock, reset, packet stimulus, back-pressure and verdict.
module tb_sync_length_checksum_deframer;
   import slcd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_BYTES = 180;
   localparam int NUM_PHASES  = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [BYTE_W-1:0]      csr_data = '0;

   int                     fail_count;
   int                     outstanding;
   logic                   at_sync;

   int                     cycle_count = 0;
   int                     burst_left = 0;
   int                     stim_bytes = 0;
   int                     stall_timer = 0;
   int                     stall_mode = 0;

   // settings last written, used to build frames
   logic [7:0]             t_sync, t_sub, t_sub2, t_mask, t_exp, t_rsp, t_dat;
   logic                   t_en;

   sync_length_checksum_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   deframe_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .at_sync     (at_sync)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sync_length_checksum_deframer] ERROR");
         $finish;
      end
   end

   // receiver: switch between always ready, random stalls and a periodic stall
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(50, 400);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 2) != 0);
         default: rsp_tready <= ((cycle_count % 7) > 2);
      endcase
   end

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] sync_v, sub_v, sub2_v, input logic en_v,
                             input logic [7:0] mask_v, exp_v, rsp_v, dat_v);
      t_sync = sync_v;
      t_sub  = sub_v;
      t_sub2 = sub2_v;
      t_en   = en_v;
      t_mask = mask_v;
      t_exp  = exp_v;
      t_rsp  = rsp_v;
      t_dat  = dat_v;
      write_csr(CSR_SYNC_VALUE, sync_v);
      write_csr(CSR_SUB_SYNC_VALUE, sub_v);
      write_csr(CSR_SUB_SYNC2_VALUE, sub2_v);
      write_csr(CSR_SUB_SYNC_ENABLE, {7'd0, en_v});
      write_csr(CSR_TYPE_MASK, mask_v);
      write_csr(CSR_EXPECTED_TYPE, exp_v);
      write_csr(CSR_RESPONSE_TYPE, rsp_v);
      write_csr(CSR_DATA_TYPE, dat_v);
      csr_valid <= 1'b0;
   endtask

   // one beat; bursts of random length with random gaps between them
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      stim_bytes++;
   endtask

   // hold off until the pipeline has drained and every result has been taken
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // send frame bytes [skip, cut) of a packet built under the current settings
   task automatic send_packet(input logic [7:0] pid, input logic [15:0] tid, code, len,
                              input logic [31:0] chk_err, input int skip, input int cut,
                              input bit extreme_fill);
      logic [7:0]  frame[$];
      logic [31:0] sum;
      logic [31:0] chk;
      logic [7:0]  pb;
      int          stop;
      frame.push_back(t_sync);
      sum = {24'd0, t_sync};
      if (t_en) begin
         frame.push_back(t_sub);
         frame.push_back(t_sub2);
         sum += t_sub;
         sum += t_sub2;
      end
      frame.push_back(pid);
      sum += pid;
      frame.push_back(tid[7:0]);
      frame.push_back(tid[15:8]);
      frame.push_back(code[7:0]);
      frame.push_back(code[15:8]);
      frame.push_back(len[7:0]);
      frame.push_back(len[15:8]);
      sum += tid;
      sum += code;
      sum += len;
      for (int i = 0; i < len; i++) begin
         pb = extreme_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
         frame.push_back(pb);
         sum += pb;
      end
      chk = 32'd0 - sum + chk_err;
      for (int i = 0; i < 4; i++) frame.push_back(chk[8*i +: 8]);
      stop = (cut < 0 || cut > frame.size()) ? frame.size() : cut;
      for (int i = skip; i < stop; i++) send_byte(frame[i]);
   endtask

   task automatic send_random_packet(input bit truncate, input bit bad_chk);
      logic [7:0]  base;
      logic [7:0]  pid;
      logic [15:0] len;
      logic [31:0] err;
      int          sel;
      int          cut;
      sel  = $urandom_range(0, 4);
      base = (sel == 0) ? t_exp : (sel == 1) ? t_rsp : (sel == 2) ? t_dat
                                                                  : 8'($urandom_range(0, 255));
      pid  = (base & t_mask) | (8'($urandom_range(0, 255)) & ~t_mask);
      sel  = $urandom_range(0, 99);
      len  = (sel < 75) ? 16'($urandom_range(0, 6))
                        : (sel < 95) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(41, 200));
      err  = 32'd0;
      if (bad_chk) begin
         err = $urandom;
         if (err == 32'd0) err = 32'd1;
      end
      cut = -1;
      if (truncate) cut = $urandom_range(1, (t_en ? 10 : 8) + len + 3);
      send_packet(pid, 16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                  len, err, 0, cut, 1'b0);
   endtask

   // bring the parser back to waiting for sync before settings change
   task automatic drain_parser();
      int tries;
      tries = 0;
      wait_idle();
      while (!at_sync && tries < 40) begin
         if (t_en) begin
            send_random_packet(1'b0, 1'b0);
         end else begin
            repeat (16) send_byte(t_sync ^ 8'h01);
         end
         wait_idle();
         tries++;
      end
   endtask

   initial begin
      int         ph;
      int         phase_end;
      int         r;
      int         n;
      logic [7:0] nb;
      logic [7:0] mask_r;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: every status, header extremes, zero length
      set_config(8'hA5, 8'h00, 8'h00, 1'b0, 8'hF0, 8'h10, 8'h20, 8'h30);
      send_packet(8'h1F, 16'h0000, 16'hFFFF, 16'd0, 32'd0, 0, -1, 1'b0);
      send_packet(8'h2A, 16'hFFFF, 16'h0000, 16'd2, 32'd0, 0, -1, 1'b0);
      send_packet(8'h35, 16'h1234, 16'h8001, 16'd3, 32'd0, 0, -1, 1'b0);
      send_packet(8'h40, 16'hA5A5, 16'h5A5A, 16'd1, 32'd0, 0, -1, 1'b0);
      send_packet(8'h10, 16'h0001, 16'h0002, 16'd4, 32'd1, 0, -1, 1'b0);
      send_packet(8'hFF, 16'hFFFF, 16'hFFFF, 16'd4, 32'd0, 0, -1, 1'b1);
      send_packet(8'h00, 16'h0000, 16'h0000, 16'd2, 32'd0, 0, -1, 1'b1);
      // last byte matches the next sync value, so the enable change sees it
      send_byte(8'h3C);
      wait_idle();

      set_config(8'h3C, 8'hC3, 8'h96, 1'b1, 8'hFF, 8'h7E, 8'h81, 8'h00);
      send_packet(8'h7E, 16'hBEEF, 16'h0102, 16'd3, 32'd0, 1, -1, 1'b0);
      send_packet(8'h81, 16'h7FFF, 16'h8000, 16'd1, 32'd0, 0, -1, 1'b0);
      // wrong first sub-sync equal to sync is not taken as a new sync
      send_byte(8'h3C);
      send_byte(8'h3C);
      send_packet(8'h00, 16'h0F0F, 16'hF0F0, 16'd0, 32'd0, 0, -1, 1'b0);
      // wrong second sub-sync
      send_byte(8'h3C);
      send_byte(8'hC3);
      send_byte(8'hFF);
      send_packet(8'h55, 16'h00FF, 16'hFF00, 16'd2, 32'd0, 0, -1, 1'b0);
      // resync inside a long payload, then inside the check word
      send_packet(8'h7E, 16'h1111, 16'h2222, 16'hFF00, 32'd0, 0, 14, 1'b0);
      send_packet(8'h7E, 16'h3333, 16'h4444, 16'd2, 32'd0, 0, -1, 1'b0);
      send_packet(8'h81, 16'h5555, 16'h6666, 16'd1, 32'd0, 0, 13, 1'b0);
      send_packet(8'h00, 16'h7777, 16'h8888, 16'd1, 32'd0, 0, -1, 1'b0);
      drain_parser();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: set_config(8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
            1: set_config(8'hFF, 8'h00, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'h00, 8'hFF);
            default: begin
               r      = $urandom_range(0, 3);
               mask_r = (r == 0) ? 8'hFF : (r == 1) ? 8'h0F : (r == 2) ? 8'hF0
                                                            : 8'($urandom_range(0, 255));
               set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), mask_r,
                          8'($urandom_range(0, 255)) & mask_r,
                          8'($urandom_range(0, 255)) & mask_r,
                          8'($urandom_range(0, 255)) & mask_r);
            end
         endcase
         phase_end = stim_bytes + PHASE_BYTES;
         while (stim_bytes < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               // noise; without resync only bytes the idle parser ignores
               n = $urandom_range(1, 6);
               repeat (n) begin
                  nb = 8'($urandom_range(0, 255));
                  if (!t_en && nb == t_sync) nb ^= 8'h01;
                  send_byte(nb);
               end
            end else if (t_en && r < 22) begin
               send_random_packet(1'b1, 1'b0);
            end else if (t_en && r < 27) begin
               send_byte(t_sync);
               if ($urandom_range(0, 1)) begin
                  send_byte(t_sub);
                  nb = 8'($urandom_range(0, 255));
                  if (nb == t_sub2) nb ^= 8'h80;
               end else begin
                  nb = 8'($urandom_range(0, 255));
                  if (nb == t_sub) nb ^= 8'h80;
               end
               send_byte(nb);
            end else begin
               send_random_packet(1'b0, $urandom_range(0, 99) < 15);
            end
         end
         drain_parser();
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("[sync_length_checksum_deframer] OK");
      end else begin
         $display("[sync_length_checksum_deframer] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/slcd_pkg.sv
sv/sync_length_checksum_deframer.sv
dv/deframe_checker.sv
dv/tb_sync_length_checksum_deframer.sv
